@@ rtl/block_partitioned_fir_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the partitioned FIR filter
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BLOCK_PARTITIONED_FIR_FILTER_ASSERT_SVH
`define BLOCK_PARTITIONED_FIR_FILTER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared constants and controller/datapath types of the partitioned FIR filter.
// ----------------------------------------------------------------------------
package bpf_pkg;

    localparam int TAP_IDX_BITS = 10;
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int ACC_BITS     = 64;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_SIZE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT  = 1'd1;

    // reset values of the registers
    localparam logic [CFG_BITS-1:0] BLOCK_SIZE_RST = 11'd64;
    localparam logic [CFG_BITS-1:0] TAP_COUNT_RST  = 11'd1;

    // item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_FILTER = 1'b1;

    typedef struct packed {
        logic clear;        // write zero at the pointer in both stores
        logic load_tap;     // write the incoming coefficient
        logic push_sample;  // write the incoming sample, start a new sum
        logic push_zero;    // write a zero pad sample
        logic mac_issue;    // read one tap/history pair into the MAC
        logic round;        // round the accumulator
        logic emit;         // saturate and load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;    // MAC pipeline still holds products
        logic out_free;     // output register can take a result
    } t_dp_sts;

endpackage

@@ rtl/bpf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_in_if
// Input item channel: coefficient loads and samples with valid/ready.
// ----------------------------------------------------------------------------
interface bpf_in_if
    import bpf_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [TAP_IDX_BITS-1:0]       tap_index;
    logic signed [SAMPLE_BITS-1:0] tap_value;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_call;

    modport source (
        output valid, func, tap_index, tap_value, sample_in, end_of_call,
        input  ready
    );
    modport sink (
        input  valid, func, tap_index, tap_value, sample_in, end_of_call,
        output ready
    );
endinterface

@@ rtl/bpf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_out_if
// Result channel: filtered sample and clip flag with valid/ready.
// ----------------------------------------------------------------------------
interface bpf_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (
        output valid, sample_out, clipped,
        input  ready
    );
    modport sink (
        input  valid, sample_out, clipped,
        output ready
    );
endinterface

@@ rtl/block_partitioned_fir_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_partitioned_fir_filter
// Long direct-form FIR filter with block-wise zero padding at end of call.
// ----------------------------------------------------------------------------
// After reset the block zeroes the coefficient and history memories, one entry
// of each per cycle, with the input held not ready; register writes are taken
// throughout. A coefficient item is written as it transfers and the input
// stays ready. A sample item holds the input not ready until it is done: the
// single multiply-accumulate unit reads one tap/history pair per cycle from
// the two single-read-port memories, a three-stage read/multiply/accumulate
// pipeline drains, a rounding step, an output load and a padding check
// follow, and when end_of_call closes a partial block the rest of it is
// padded with zero samples, one per cycle. The finished result sits in an
// output register, so the next item is accepted while it waits to be taken;
// a second result waits in the sequencer until that register frees up.
// ----------------------------------------------------------------------------
module block_partitioned_fir_filter
    import bpf_pkg::*;
#(
    parameter int MAX_TAPS    = 1024,
    parameter int MAX_BLOCK   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // register write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    // input item channel
    bpf_in_if.sink                  i_in,
    // result channel
    bpf_out_if.source               o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // Sequencer owns the registers, the tap loop count and block position.
    bpf_ctrl #(
        .MAX_TAPS  (MAX_TAPS),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.func),
        .i_in_eoc    (i_in.end_of_call),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath holds both memories, the history pointer and the MAC.
    bpf_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_tap_index (i_in.tap_index),
        .i_tap_value (i_in.tap_value),
        .i_sample_in (i_in.sample_in),
        .o_out       (o_out)
    );

    assign i_in.ready = w_in_ready;

endmodule

@@ rtl/bpf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_ctrl
// Sequencer: clearing pass, item dispatch, MAC loop, rounding, zero padding.
// ----------------------------------------------------------------------------
module bpf_ctrl
    import bpf_pkg::*;
#(
    parameter int MAX_TAPS  = 1024,
    parameter int MAX_BLOCK = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_func,
    input  logic                    i_in_eoc,
    output logic                    o_in_ready,
    output t_dp_cmd                 o_cmd,
    input  t_dp_sts                 i_sts
);

    localparam int KBITS   = $clog2(MAX_TAPS + 1);
    localparam int POSBITS = $clog2(MAX_BLOCK + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_PAD   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [KBITS-1:0]   r_k, n_k;
    logic [POSBITS-1:0] r_pos, n_pos;
    logic               r_eoc, n_eoc;
    logic [CFG_BITS-1:0] r_block_size, r_tap_count;

    logic [KBITS-1:0]   w_tc;
    logic [POSBITS-1:0] w_bs;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RST;
            r_tap_count  <= TAP_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLOCK_SIZE: r_block_size <= i_cfg_data;
                CFG_TAP_COUNT:  r_tap_count  <= i_cfg_data;
            endcase
        end
    end

    // clamp counts to [1, max]
    always_comb begin
        if (r_tap_count == '0) begin
            w_tc = KBITS'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            w_tc = KBITS'(MAX_TAPS);
        end else begin
            w_tc = KBITS'(r_tap_count);
        end
        if (r_block_size == '0) begin
            w_bs = POSBITS'(1);
        end else if (32'(r_block_size) > MAX_BLOCK) begin
            w_bs = POSBITS'(MAX_BLOCK);
        end else begin
            w_bs = POSBITS'(r_block_size);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_pos      = r_pos;
        n_eoc      = r_eoc;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (r_k == KBITS'(MAX_TAPS - 1)) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == FUNC_LOAD) begin
                        o_cmd.load_tap = 1'b1;
                    end else begin
                        o_cmd.push_sample = 1'b1;
                        n_eoc   = i_in_eoc;
                        n_pos   = r_pos + 1'b1;
                        n_k     = '0;
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (r_k == w_tc - 1'b1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_PAD;
                end
            end
            S_PAD: begin
                // end of call on a partial block: fill it with zeros
                if (r_eoc && (r_pos < w_bs)) begin
                    o_cmd.push_zero = 1'b1;
                    n_pos           = r_pos + 1'b1;
                end else begin
                    if (r_eoc || (r_pos >= w_bs)) begin
                        n_pos = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_pos   <= '0;
            r_eoc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_eoc   <= n_eoc;
        end
    end

endmodule

@@ rtl/bpf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_datapath
// Tap and history stores, MAC pipeline, rounding, saturation, output register.
// ----------------------------------------------------------------------------
module bpf_datapath
    import bpf_pkg::*;
#(
    parameter int MAX_TAPS    = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic [TAP_IDX_BITS-1:0]       i_tap_index,
    input  logic signed [SAMPLE_BITS-1:0] i_tap_value,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    bpf_out_if.source                     o_out
);

    localparam int ABITS    = $clog2(MAX_TAPS);
    localparam int PBITS    = 2 * SAMPLE_BITS;
    localparam int RND_BITS = ACC_BITS - SAMPLE_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] r_tap_mem  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_hist_mem [MAX_TAPS];

    logic [ABITS-1:0]              r_ptr;
    logic [ABITS-1:0]              r_tap_raddr, r_hist_raddr;
    logic signed [SAMPLE_BITS-1:0] r_tap_rd, r_hist_rd;
    logic                          r_v1, r_v2;
    logic signed [PBITS-1:0]       r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [RND_BITS-1:0]    r_rnd;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_clip;

    logic                          w_tap_we, w_hist_we;
    logic [ABITS-1:0]              w_tap_waddr, w_ptr_inc;
    logic signed [SAMPLE_BITS-1:0] w_tap_wdata, w_hist_wdata;
    logic [ACC_BITS-1:0]           w_sum;
    logic [RND_BITS-SAMPLE_BITS:0] w_hi;
    logic                          w_ovf;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    assign w_ptr_inc = (r_ptr == ABITS'(MAX_TAPS - 1)) ? '0 : r_ptr + 1'b1;

    assign w_tap_we    = i_cmd.clear
                       || (i_cmd.load_tap && (32'(i_tap_index) < MAX_TAPS));
    assign w_tap_waddr = i_cmd.clear ? r_ptr : ABITS'(i_tap_index);
    assign w_tap_wdata = i_cmd.clear ? '0 : i_tap_value;

    assign w_hist_we    = i_cmd.clear || i_cmd.push_sample || i_cmd.push_zero;
    assign w_hist_wdata = i_cmd.push_sample ? i_sample_in : '0;

    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            r_tap_mem[w_tap_waddr] <= w_tap_wdata;
        end
        r_tap_rd <= r_tap_mem[r_tap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist_mem[r_ptr] <= w_hist_wdata;
        end
        r_hist_rd <= r_hist_mem[r_hist_raddr];
    end

    // read addresses walk taps up and history back from the newest sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_sample) begin
            r_tap_raddr  <= '0;
            r_hist_raddr <= r_ptr;
        end else if (i_cmd.mac_issue) begin
            r_tap_raddr  <= r_tap_raddr + 1'b1;
            r_hist_raddr <= (r_hist_raddr == '0) ? ABITS'(MAX_TAPS - 1)
                                                 : r_hist_raddr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (w_hist_we) begin
                r_ptr <= w_ptr_inc;
            end
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    // MAC: accumulator wraps modulo 2^ACC_BITS
    always_ff @(posedge i_clk) begin
        r_prod <= r_tap_rd * r_hist_rd;
        if (i_cmd.push_sample) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_BITS'(r_prod);
        end
    end

    // round half up, then floor shift
    assign w_sum = r_acc + (ACC_BITS'(1) << (SAMPLE_BITS - 2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            r_rnd <= w_sum[ACC_BITS-1:SAMPLE_BITS-1];
        end
    end

    // overflow when the bits above the result are not a sign extension
    assign w_hi  = r_rnd[RND_BITS-1:SAMPLE_BITS-1];
    assign w_ovf = !((&w_hi) || !(|w_hi));
    assign w_sat = r_rnd[RND_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample <= w_ovf ? w_sat : r_rnd[SAMPLE_BITS-1:0];
            r_out_clip   <= w_ovf;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.clipped    = r_out_clip;

    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = !r_out_valid || o_out.ready;

endmodule

@@ rtl/bpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_checker
// Port-level checks of the partitioned FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_partitioned_fir_filter_assert.svh"

module bpf_checker
    import bpf_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_func,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_out_sample,
    input logic                          i_out_clipped
);

    logic [1:0]           r_pend;
    logic                 w_smp_xfer, w_out_xfer;
    logic                 w_out_stall;
    logic [SAMPLE_BITS:0] w_out_word;

    assign w_smp_xfer  = i_in_valid && i_in_ready && (i_in_func == FUNC_FILTER);
    assign w_out_xfer  = i_out_valid && i_out_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_out_word  = {i_out_sample, i_out_clipped};

    // samples accepted whose results have not been transferred yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(w_smp_xfer) - 2'(w_out_xfer);
        end
    end

    `BPF_ASSERT_NEXT(a_out_hold, w_out_stall, i_out_valid, "result dropped")
    `BPF_ASSERT_NEXT(a_out_stable, w_out_stall, $stable(w_out_word), "stalled result changed")
    `BPF_ASSERT_NOW(a_no_phantom, i_out_valid, r_pend != 2'd0, "result without a sample")
    `BPF_ASSERT_NOW(a_pend_bound, 1'b1, r_pend != 2'd3, "too many results outstanding")
    `BPF_ASSERT_NEXT(a_busy_after, w_smp_xfer, !i_in_ready, "ready during tap loop")

endmodule

bind block_partitioned_fir_filter bpf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_func     (i_in.func),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_sample  (o_out.sample_out),
    .i_out_clipped (o_out.clipped)
);
